// File: rtl/core/ghp_pkg.sv
package ghp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } byte_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] payload_byte;
        logic [7:0] header_flags;
    } result_item_t;

    localparam logic [3:0] PH_MAGIC1  = 4'd0;
    localparam logic [3:0] PH_MAGIC2  = 4'd1;
    localparam logic [3:0] PH_METHOD  = 4'd2;
    localparam logic [3:0] PH_FLAGS   = 4'd3;
    localparam logic [3:0] PH_FIXED   = 4'd4;
    localparam logic [3:0] PH_XLEN_LO = 4'd5;
    localparam logic [3:0] PH_XLEN_HI = 4'd6;
    localparam logic [3:0] PH_EXTRA   = 4'd7;
    localparam logic [3:0] PH_NAME    = 4'd8;
    localparam logic [3:0] PH_COMMENT = 4'd9;
    localparam logic [3:0] PH_PAYLOAD = 4'd10;
    localparam logic [3:0] PH_STOPPED = 4'd11;

    localparam logic [3:0] ST_HEADER       = 4'd0;
    localparam logic [3:0] ST_HEADER_DONE  = 4'd1;
    localparam logic [3:0] ST_PAYLOAD      = 4'd2;
    localparam logic [3:0] ST_BAD_MAGIC    = 4'd3;
    localparam logic [3:0] ST_BAD_METHOD   = 4'd4;
    localparam logic [3:0] ST_ENCRYPTED    = 4'd5;
    localparam logic [3:0] ST_CONTINUATION = 4'd6;
    localparam logic [3:0] ST_BAD_FLAGS    = 4'd7;
    localparam logic [3:0] ST_STOPPED      = 4'd8;

    localparam logic [7:0] MAGIC_ID1      = 8'h1f;
    localparam logic [7:0] MAGIC_ID2      = 8'h8b;
    localparam logic [7:0] MAGIC_ID2_ALT  = 8'h9e;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    localparam logic [7:0] FLG_CONT      = 8'h02;
    localparam logic [7:0] FLG_EXTRA     = 8'h04;
    localparam logic [7:0] FLG_NAME      = 8'h08;
    localparam logic [7:0] FLG_COMMENT   = 8'h10;
    localparam logic [7:0] FLG_ENCRYPTED = 8'h20;
    localparam logic [7:0] FLG_RESERVED  = 8'hc0;

    localparam logic [2:0] FIXED_LAST = 3'd5;

endpackage

// File: rtl/core/ghp_core.sv
module ghp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ghp_pkg::byte_item_t item,
    output ghp_pkg::result_item_t result
);
    import ghp_pkg::*;

    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] status;
    } adv_t;

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  fixed_reg, fixed_next;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  xlen_lo_reg, xlen_lo_next;

    logic [3:0]  cur_phase;
    logic [2:0]  cur_fixed;
    logic [7:0]  cur_flag;
    logic [15:0] cur_rem;
    logic [7:0]  cur_lo;
    logic [15:0] rem_dec;
    logic [3:0]  status;
    logic [7:0]  pay;
    logic [7:0]  b;
    adv_t        adv;

    // next optional header part after the given one, or header done
    function automatic adv_t advance_from(input logic [3:0] from, input logic [7:0] flags);
        adv_t r;
        if (from < PH_XLEN_LO && (flags & FLG_EXTRA) != 8'd0)
        begin
            r.phase  = PH_XLEN_LO;
            r.status = ST_HEADER;
        end
        else if (from < PH_NAME && (flags & FLG_NAME) != 8'd0)
        begin
            r.phase  = PH_NAME;
            r.status = ST_HEADER;
        end
        else if (from < PH_COMMENT && (flags & FLG_COMMENT) != 8'd0)
        begin
            r.phase  = PH_COMMENT;
            r.status = ST_HEADER;
        end
        else
        begin
            r.phase  = PH_PAYLOAD;
            r.status = ST_HEADER_DONE;
        end
        return r;
    endfunction

    assign b       = item.data_byte;
    assign rem_dec = cur_rem - 16'd1;

    always_comb
    begin
        // start mark restarts the parser on this very item
        cur_phase = item.stream_start ? PH_MAGIC1 : phase_reg;
        cur_fixed = item.stream_start ? 3'd0 : fixed_reg;
        cur_flag  = item.stream_start ? 8'd0 : flag_reg;
        cur_rem   = item.stream_start ? 16'd0 : rem_reg;
        cur_lo    = item.stream_start ? 8'd0 : xlen_lo_reg;

        phase_next   = cur_phase;
        fixed_next   = cur_fixed;
        flag_next    = cur_flag;
        rem_next     = cur_rem;
        xlen_lo_next = cur_lo;
        status       = ST_HEADER;
        pay          = 8'd0;
        adv          = advance_from(cur_phase, cur_flag);

        case (cur_phase)
            PH_MAGIC1:
            begin
                if (b != MAGIC_ID1)
                begin
                    status     = ST_BAD_MAGIC;
                    phase_next = PH_STOPPED;
                end
                else
                    phase_next = PH_MAGIC2;
            end
            PH_MAGIC2:
            begin
                if (b != MAGIC_ID2 && b != MAGIC_ID2_ALT)
                begin
                    status     = ST_BAD_MAGIC;
                    phase_next = PH_STOPPED;
                end
                else
                    phase_next = PH_METHOD;
            end
            PH_METHOD:
            begin
                if (b != METHOD_DEFLATE)
                begin
                    status     = ST_BAD_METHOD;
                    phase_next = PH_STOPPED;
                end
                else
                    phase_next = PH_FLAGS;
            end
            PH_FLAGS:
            begin
                flag_next = b;
                if ((b & FLG_ENCRYPTED) != 8'd0)
                begin
                    status     = ST_ENCRYPTED;
                    phase_next = PH_STOPPED;
                end
                else if ((b & FLG_CONT) != 8'd0)
                begin
                    status     = ST_CONTINUATION;
                    phase_next = PH_STOPPED;
                end
                else if ((b & FLG_RESERVED) != 8'd0)
                begin
                    status     = ST_BAD_FLAGS;
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    fixed_next = 3'd0;
                    phase_next = PH_FIXED;
                end
            end
            PH_FIXED:
            begin
                if (cur_fixed >= FIXED_LAST)
                begin
                    fixed_next = 3'd0;
                    adv        = advance_from(PH_FIXED, cur_flag);
                    status     = adv.status;
                    phase_next = adv.phase;
                end
                else
                    fixed_next = cur_fixed + 3'd1;
            end
            PH_XLEN_LO:
            begin
                xlen_lo_next = b;
                phase_next   = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                rem_next = {b, cur_lo};
                if ({b, cur_lo} == 16'd0)
                begin
                    adv        = advance_from(PH_EXTRA, cur_flag);
                    status     = adv.status;
                    phase_next = adv.phase;
                end
                else
                    phase_next = PH_EXTRA;
            end
            PH_EXTRA:
            begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    adv        = advance_from(PH_EXTRA, cur_flag);
                    status     = adv.status;
                    phase_next = adv.phase;
                end
            end
            PH_NAME:
            begin
                if (b == 8'd0)
                begin
                    adv        = advance_from(PH_NAME, cur_flag);
                    status     = adv.status;
                    phase_next = adv.phase;
                end
            end
            PH_COMMENT:
            begin
                if (b == 8'd0)
                begin
                    adv        = advance_from(PH_COMMENT, cur_flag);
                    status     = adv.status;
                    phase_next = adv.phase;
                end
            end
            PH_PAYLOAD:
            begin
                status = ST_PAYLOAD;
                pay    = b;
            end
            default:
            begin
                status     = ST_STOPPED;
                phase_next = PH_STOPPED;
            end
        endcase
    end

    assign result.status       = status;
    assign result.payload_byte = pay;
    assign result.header_flags = flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC1;
            fixed_reg   <= 3'd0;
            flag_reg    <= 8'd0;
            rem_reg     <= 16'd0;
            xlen_lo_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            fixed_reg   <= fixed_next;
            flag_reg    <= flag_next;
            rem_reg     <= rem_next;
            xlen_lo_reg <= xlen_lo_next;
        end
    end

endmodule

// File: rtl/core/gzip_header_parser.sv
// gzip member header parser. One byte item in, one result item out, at up to one item
// per clock when nothing stalls. Each item passes an input register, then the parser
// state update, then a result register. The state update sets the rate: every byte
// depends on the parser state left by the previous one. stream_start restarts the parser
// on the byte that carries it; bytes before any start mark are parsed as a fresh stream.
module gzip_header_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  ghp_pkg::byte_item_t   byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ghp_pkg::result_item_t result_item
);
    import ghp_pkg::*;

    logic         byte_valid_reg, byte_valid_next;
    byte_item_t   byte_item_reg;
    logic         result_valid_reg, result_valid_next;
    result_item_t result_item_reg;
    result_item_t core_result;
    logic         advance;

    assign advance    = byte_valid_reg && (!result_valid_reg || !result_stall);
    assign byte_stall = byte_valid_reg && !advance;

    assign byte_valid_next   = byte_stall ? byte_valid_reg : byte_valid;
    assign result_valid_next = advance ? 1'b1 : (result_stall ? result_valid_reg : 1'b0);

    ghp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (byte_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg   <= byte_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            byte_item_reg <= byte_item;
        if (advance)
            result_item_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

// File: rtl/core/ghp_checker.sv
module ghp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_valid,
    input logic                  byte_stall,
    input ghp_pkg::byte_item_t   byte_item,
    input logic                  result_valid,
    input logic                  result_stall,
    input ghp_pkg::result_item_t result_item
);
    import ghp_pkg::*;

    // a stalled byte item holds
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
        else $error("byte item changed while stalled");

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status != ST_PAYLOAD |-> result_item.payload_byte == 8'd0)
        else $error("payload byte set outside payload");

    // magic and method errors come before the flag byte is read
    a_early_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.status == ST_BAD_MAGIC ||
                         result_item.status == ST_BAD_METHOD)
        |-> result_item.header_flags == 8'd0)
        else $error("header flags set on early error");

    a_encrypted_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == ST_ENCRYPTED |-> result_item.header_flags[5])
        else $error("encrypted status without encrypted flag");

endmodule

bind gzip_header_parser ghp_checker u_ghp_checker (.*);
